// ===== design/size_class_buffer_pool_defines.svh =====
// Assertion macros shared by the checker of the size class buffer pool.
`ifndef SIZE_CLASS_BUFFER_POOL_DEFINES_SVH
`define SIZE_CLASS_BUFFER_POOL_DEFINES_SVH

// Concurrent assertion on a named clock and active-low reset.
`define SCBP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("size class buffer pool: property failed");

// The same on the block's own clock and reset.
`define SCBP_ASSERT_CLK(lbl, prop) `SCBP_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

// ===== design/scbp_pkg.sv =====
package scbp_pkg;

    // Field widths fixed by the interface.
    localparam int LEN_W   = 16;
    localparam int ID_W    = 10;
    localparam int STAT_W  = 3;
    localparam int CLS_W   = 4;
    localparam int BYTES_W = 20;
    localparam int STEP_W  = 16;

    // Internal class index wide enough for the largest supported class count.
    localparam int QCLS_W = 6;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ALLOCATED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLASS_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED_POOL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREED_OUTSIDE = 3'd4;

    // Register word index on the configuration port.
    localparam logic REG_SIZE_STEP = 1'b0;

    // Request operation codes.
    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [LEN_W-1:0] length;
        logic [ID_W-1:0]  buffer_id;
        logic             from_pool;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    granted_id;
        logic [CLS_W-1:0]   size_class;
        logic [BYTES_W-1:0] class_bytes;
    } t_res;

    // Classified request kinds handed from the front to the back.
    typedef enum logic [1:0] {
        K_ALLOC,
        K_TOO_LARGE,
        K_FREE,
        K_OUTSIDE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [QCLS_W-1:0] cls;
        logic [ID_W-1:0]   id;
    } t_qent;

    // Status of the back part seen by the top level.
    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// ===== design/scbp_ram.sv =====
module scbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/scbp_front.sv =====
module scbp_front
    import scbp_pkg::*;
#(
    parameter int CLASS_COUNT       = 16,
    parameter int BUFFERS_PER_CLASS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_req              i_req,
    input  logic [STEP_W-1:0] i_size_step,
    input  logic              i_full,
    output logic              o_active,
    output logic              o_push,
    output t_qent             o_entry
);

    localparam int TOTAL  = CLASS_COUNT * BUFFERS_PER_CLASS;
    localparam int SW     = $clog2(CLASS_COUNT + 1);
    localparam int PW     = SW + STEP_W;
    // Reciprocal for the class of a freed id: exact for every 10-bit id.
    localparam int RS     = ID_W + $clog2(BUFFERS_PER_CLASS);
    localparam int FW     = RS + ID_W + 1;
    localparam longint RECIP = ((64'd1 << RS) + BUFFERS_PER_CLASS - 1) / BUFFERS_PER_CLASS;

    logic          r_active;
    t_req          r_req;
    logic [SW-1:0] r_lo;
    logic [SW-1:0] r_hi;

    logic [SW:0]   w_sum;
    logic [SW-1:0] w_mid;
    logic [SW-1:0] w_mid1;
    logic [PW-1:0] w_prod;
    logic          w_fits;
    logic [FW-1:0] w_fprod;
    logic          w_outside;
    logic          w_step_zero;
    logic          w_done;

    // One step of the binary search: does class mid cover the length?
    always_comb begin
        w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        w_mid  = w_sum[SW:1];
        w_mid1 = w_mid + SW'(1);
        w_prod = PW'(w_mid1) * PW'(i_size_step);
        w_fits = PW'(r_req.length) <= w_prod;
    end

    // Class of a freed buffer and the foreign-buffer check.
    always_comb begin
        w_fprod     = FW'(r_req.buffer_id) * FW'(RECIP);
        w_outside   = !r_req.from_pool || (32'(r_req.buffer_id) >= TOTAL);
        w_step_zero = (i_size_step == '0);
        w_done      = (r_req.operation == OP_FREE) || w_step_zero || (r_lo == r_hi);
    end

    // Classified entry for the queue.
    always_comb begin
        o_entry = '0;
        if (r_req.operation == OP_FREE) begin
            o_entry.id = r_req.buffer_id;
            if (w_outside) begin
                o_entry.kind = K_OUTSIDE;
            end else begin
                o_entry.kind = K_FREE;
                o_entry.cls  = QCLS_W'(w_fprod >> RS);
            end
        end else if (w_step_zero || (r_lo == SW'(CLASS_COUNT))) begin
            o_entry.kind = K_TOO_LARGE;
        end else begin
            o_entry.kind = K_ALLOC;
            o_entry.cls  = QCLS_W'(r_lo);
        end
    end

    assign o_push   = r_active && w_done && !i_full;
    assign o_active = r_active;

    // Request register and search bounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (!r_active) begin
            if (i_start) begin
                r_active <= 1'b1;
                r_req    <= i_req;
                r_lo     <= '0;
                r_hi     <= SW'(CLASS_COUNT);
            end
        end else if (!w_done) begin
            if (w_fits) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid1;
            end
        end else if (!i_full) begin
            r_active <= 1'b0;
        end
    end

endmodule

// ===== design/scbp_queue.sv =====
module scbp_queue
    import scbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_qent o_entry
);

    t_qent      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_slot[r_rp];

    // Two-entry queue between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_slot[r_wp] <= i_entry;
                r_wp         <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== design/scbp_back.sv =====
module scbp_back
    import scbp_pkg::*;
#(
    parameter int CLASS_COUNT       = 16,
    parameter int BUFFERS_PER_CLASS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_qent             i_entry,
    input  logic [STEP_W-1:0] i_size_step,
    output logic              o_pop,
    output t_back_stat        o_stat,
    output logic              o_done,
    output t_res              o_res
);

    localparam int TOTAL = CLASS_COUNT * BUFFERS_PER_CLASS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int HAW   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int KW    = (BUFFERS_PER_CLASS > 1) ? $clog2(BUFFERS_PER_CLASS) : 1;
    localparam int BPW   = QCLS_W + STEP_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_LINK
    } t_state;

    t_state             r_state;
    t_qent              r_cur;
    logic [BYTES_W-1:0] r_bytes;
    logic [AW-1:0]      r_top;
    logic               r_done;
    t_res               r_res;
    logic [AW-1:0]      r_clr_id;
    logic [KW-1:0]      r_clr_k;
    logic [HAW-1:0]     r_clr_cls;

    logic           h_we;
    logic [HAW-1:0] h_waddr;
    logic [AW:0]    h_wdata;
    logic [HAW-1:0] h_raddr;
    logic [AW:0]    h_rdata;
    logic           l_we;
    logic [AW-1:0]  l_waddr;
    logic [AW:0]    l_wdata;
    logic [AW-1:0]  l_raddr;
    logic [AW:0]    l_rdata;

    logic [QCLS_W:0]  w_cls1;
    logic [BPW-1:0]   w_bytes;
    logic             w_clr_last;

    // List heads: {nonempty, head id} per class.
    scbp_ram #(.WIDTH(AW + 1), .DEPTH(CLASS_COUNT)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // Links: {valid, next id} per buffer.
    scbp_ram #(.WIDTH(AW + 1), .DEPTH(TOTAL)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // Capacity of the class at the head of the queue.
    always_comb begin
        w_cls1     = (QCLS_W + 1)'(i_entry.cls) + (QCLS_W + 1)'(1);
        w_bytes    = BPW'(w_cls1) * BPW'(i_size_step);
        w_clr_last = (r_clr_k == KW'(BUFFERS_PER_CLASS - 1));
    end

    // Memory port control for each step of a request and the clearing pass.
    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_cur.cls[HAW-1:0];
        h_wdata = '0;
        h_raddr = i_entry.cls[HAW-1:0];
        l_we    = 1'b0;
        l_waddr = AW'(r_cur.id);
        l_wdata = '0;
        l_raddr = h_rdata[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                l_we    = 1'b1;
                l_waddr = r_clr_id;
                l_wdata = w_clr_last ? '0 : {1'b1, AW'(r_clr_id + 1'b1)};
                h_we    = (r_clr_k == '0);
                h_waddr = r_clr_cls;
                h_wdata = {1'b1, r_clr_id};
            end
            S_HEAD: begin
                if (r_cur.kind == K_FREE) begin
                    l_we    = 1'b1;
                    l_wdata = h_rdata[AW] ? h_rdata : '0;
                    h_we    = 1'b1;
                    h_wdata = {1'b1, AW'(r_cur.id)};
                end
            end
            S_LINK: begin
                h_we    = 1'b1;
                h_wdata = l_rdata[AW] ? l_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    assign o_pop           = (r_state == S_IDLE) && !i_empty;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_done          = r_done;
    assign o_res           = r_res;

    // Sequencer: clearing pass after reset, then head read, link read, write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_done    <= 1'b0;
            r_clr_id  <= '0;
            r_clr_k   <= '0;
            r_clr_cls <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_id == AW'(TOTAL - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_id <= r_clr_id + 1'b1;
                        if (w_clr_last) begin
                            r_clr_k   <= '0;
                            r_clr_cls <= r_clr_cls + 1'b1;
                        end else begin
                            r_clr_k <= r_clr_k + 1'b1;
                        end
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cur   <= i_entry;
                        r_bytes <= w_bytes[BYTES_W-1:0];
                        case (i_entry.kind) inside
                            K_TOO_LARGE, K_OUTSIDE: begin
                                r_done <= 1'b1;
                                r_res  <= {((i_entry.kind == K_TOO_LARGE) ?
                                            ST_TOO_LARGE : ST_FREED_OUTSIDE),
                                           {(ID_W + CLS_W + BYTES_W){1'b0}}};
                            end
                            default: begin
                                r_state <= S_HEAD;
                            end
                        endcase
                    end
                end
                S_HEAD: begin
                    r_res.granted_id  <= '0;
                    r_res.size_class  <= r_cur.cls[CLS_W-1:0];
                    r_res.class_bytes <= r_bytes;
                    if (r_cur.kind == K_FREE) begin
                        r_done       <= 1'b1;
                        r_res.status <= ST_FREED_POOL;
                        r_state      <= S_IDLE;
                    end else if (!h_rdata[AW]) begin
                        r_done       <= 1'b1;
                        r_res.status <= ST_CLASS_EMPTY;
                        r_state      <= S_IDLE;
                    end else begin
                        r_top   <= h_rdata[AW-1:0];
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_done           <= 1'b1;
                    r_res.status     <= ST_ALLOCATED;
                    r_res.granted_id <= ID_W'(r_top);
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/size_class_buffer_pool.sv =====
// Packet buffer pool with CLASS_COUNT size classes of BUFFERS_PER_CLASS buffers each; class i
// holds buffers of (i+1)*size_step bytes. A request is a transfer taken when start is high and
// busy is low; its result appears on o_res for one cycle with o_done high and must be taken
// then, since the receiver cannot stall. After reset the block sweeps the link memory once,
// one buffer a cycle, and busy stays high until all CLASS_COUNT*BUFFERS_PER_CLASS buffers
// (1024 at the defaults) are linked. A free needs no search; busy drops once its entry is
// pushed into the queue; the push waits while the queue is full. An allocate runs a binary
// search of the class in the front, one multiply-and-compare per cycle, and busy stays high
// until its entry is pushed; a zero size step ends the search at once. For an allocate
// the back reads the class head, then the link memory, and makes the next id the head; for a
// free it reads the head and writes the link and the new head; too-large and outside results
// come from idle. A two-entry queue lets the back run behind. Results leave in request order.
module size_class_buffer_pool
    import scbp_pkg::*;
#(
    parameter int CLASS_COUNT       = 16,
    parameter int BUFFERS_PER_CLASS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res
);

    logic [STEP_W-1:0] r_size_step;

    logic       front_active;
    logic       q_push;
    t_qent      q_in;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    t_qent      q_out;
    t_back_stat back_stat;

    // Configuration register, written on the access phase of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_step <= STEP_W'(256);
        end else if (psel && penable && pwrite && (paddr[2] == REG_SIZE_STEP)) begin
            r_size_step <= pwdata[STEP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIZE_STEP) ? 32'(r_size_step) : 32'd0;

    assign busy = front_active || back_stat.clearing;

    scbp_front #(
        .CLASS_COUNT       (CLASS_COUNT),
        .BUFFERS_PER_CLASS (BUFFERS_PER_CLASS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !busy),
        .i_req       (i_req),
        .i_size_step (r_size_step),
        .i_full      (q_full),
        .o_active    (front_active),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    scbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    scbp_back #(
        .CLASS_COUNT       (CLASS_COUNT),
        .BUFFERS_PER_CLASS (BUFFERS_PER_CLASS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_entry     (q_out),
        .i_size_step (r_size_step),
        .o_pop       (q_pop),
        .o_stat      (back_stat),
        .o_done      (o_done),
        .o_res       (o_res)
    );

endmodule

// ===== design/scbp_checker.sv =====
`include "size_class_buffer_pool_defines.svh"

module scbp_checker
    import scbp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_res o_res
);

    logic [3:0] r_outst;
    logic       w_no_grant;
    logic       w_reject;
    logic       w_no_class;

    // Requests accepted whose results have not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 4'(start && !busy) - 4'(o_done);
        end
    end

    // Result kinds that carry no buffer, and those that carry no class.
    always_comb begin
        w_no_grant = o_done && (o_res.status != ST_ALLOCATED);
        w_reject   = o_done && ((o_res.status == ST_TOO_LARGE) ||
                                (o_res.status == ST_FREED_OUTSIDE));
        w_no_class = (o_res.size_class == '0) && (o_res.class_bytes == '0);
    end

    `SCBP_ASSERT_CLK(a_busy_after_start, (start && !busy) |=> busy)
    `SCBP_ASSERT_CLK(a_done_has_request, o_done |-> (r_outst != 4'd0))
    `SCBP_ASSERT_CLK(a_grant_only_on_alloc, w_no_grant |-> (o_res.granted_id == '0))
    `SCBP_ASSERT_CLK(a_no_class_on_reject, w_reject |-> w_no_class)

endmodule

bind size_class_buffer_pool scbp_checker u_scbp_checker (.*);
